// ===== rtl/e2mq_pkg.sv =====
// Shared constants, types and coefficient tables for the Euler angle converter.
package e2mq_pkg;

   // Fixed-point formats of the angle inputs and the result words.
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int OUT_FRAC_BITS = 16;

   // Angles inside the block carry one more fraction bit, so the half angle is exact.
   localparam int ANG_SHIFT = ANGLE_FRAC_BITS + 1;
   localparam int ANG_W = 17;
   localparam int QUARTER = 90 << ANG_SHIFT;
   localparam int FULL = 4 * QUARTER;
   localparam int HALF_Q = QUARTER / 2;
   localparam int R_W = $clog2(FULL);
   localparam int UT_W = $clog2(HALF_Q + 1);

   // pi/180 in Q30.
   localparam int DEG_TO_RAD = 18740330;
   localparam int DR_W = 25;
   localparam int XM_W = UT_W + DR_W;

   localparam int Q30_ONE = 1 << 30;
   localparam int SC_W = 32;
   localparam int SUM_W = SC_W + 1;
   localparam int VAL_W = 18;
   localparam int VAL_MAX = (1 << (VAL_W - 1)) - 1;
   localparam int VAL_MIN = -(1 << (VAL_W - 1));

   // Horner steps: the cosine uses all of them, the sine the first SIN_STEPS.
   localparam int NSTEPS = 6;
   localparam int SIN_STEPS = 5;

   localparam logic [1:0] ROW_QUAT = 2'd3;
   localparam logic [1:0] ANG_BANK = 2'd2;

   typedef struct packed {
      logic [29:0] x2;
      logic [30:0] ps;
      logic [30:0] pc;
   } horner_type;

   typedef struct packed {
      logic signed [SC_W-1:0] s;
      logic signed [SC_W-1:0] c;
   } angle_pair_type;

   typedef struct packed {
      logic [1:0] row;
      logic signed [VAL_W-1:0] a;
      logic signed [VAL_W-1:0] b;
      logic signed [VAL_W-1:0] c;
      logic signed [VAL_W-1:0] d;
      logic last;
   } rsp_type;

   function automatic int sin_k(input int step);
      case (step)
         0: sin_k = 110;
         1: sin_k = 72;
         2: sin_k = 42;
         3: sin_k = 20;
         default: sin_k = 6;
      endcase
   endfunction

   function automatic int cos_k(input int step);
      case (step)
         0: cos_k = 132;
         1: cos_k = 90;
         2: cos_k = 56;
         3: cos_k = 30;
         4: cos_k = 12;
         default: cos_k = 2;
      endcase
   endfunction

endpackage

// ===== rtl/e2mq_cell.sv =====
// One Horner step of the sine and cosine polynomials, three register stages deep.
module e2mq_cell import e2mq_pkg::*; #(
   parameter int STEP = 0,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  horner_type        in_h,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output horner_type        out_h,
   output logic [SIDE_W-1:0] out_side
);

   localparam logic [7:0] KC = 8'(cos_k(STEP));
   localparam logic [31:0] MC = 32'((64'd1 << 32) / cos_k(STEP));

   logic v1_ff, v2_ff, v3_ff;
   logic [SIDE_W-1:0] side1_ff, side2_ff, side3_ff;
   logic [29:0] x2_1_ff, x2_2_ff, x2_3_ff;
   logic [60:0] prodc1_ff;
   logic [29:0] vc2_ff;
   logic [61:0] mqc2_ff;
   logic [30:0] pc3_ff;
   logic [30:0] ps3;
   logic [29:0] vc;

   // Product rounded half up and brought back to Q30.
   function automatic logic [29:0] round30(input logic [60:0] p);
      logic [60:0] s;
      begin
         s = p + 61'(1 << 29);
         round30 = s[59:30];
      end
   endfunction

   // The reciprocal product is at most one short of the true quotient.
   function automatic logic [30:0] next_p(input logic [29:0] v, input logic [29:0] q0,
                                          input logic [7:0] k);
      logic [29:0] rem;
      logic [29:0] q;
      begin
         rem = v - 30'(38'(q0) * 38'(k));
         q = q0 + 30'(rem >= 30'(k));
         next_p = 31'(Q30_ONE) - {1'b0, q};
      end
   endfunction

   assign vc = round30(prodc1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= in_side;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
         x2_1_ff <= in_h.x2;
         x2_2_ff <= x2_1_ff;
         x2_3_ff <= x2_2_ff;
         prodc1_ff <= 61'(in_h.x2) * 61'(in_h.pc);
         vc2_ff <= vc;
         mqc2_ff <= 62'(vc) * 62'(MC);
         pc3_ff <= next_p(vc2_ff, mqc2_ff[61:32], KC);
      end
   end

   generate
      if (STEP < SIN_STEPS) begin : g_sin
         localparam logic [7:0] KS = 8'(sin_k(STEP));
         localparam logic [31:0] MS = 32'((64'd1 << 32) / sin_k(STEP));
         logic [60:0] prods1_ff;
         logic [29:0] vs2_ff;
         logic [61:0] mqs2_ff;
         logic [30:0] ps3_ff;
         logic [29:0] vs;

         assign vs = round30(prods1_ff);
         always_ff @(posedge clock) begin
            if (en) begin
               prods1_ff <= 61'(in_h.x2) * 61'(in_h.ps);
               vs2_ff <= vs;
               mqs2_ff <= 62'(vs) * 62'(MS);
               ps3_ff <= next_p(vs2_ff, mqs2_ff[61:32], KS);
            end
         end
         assign ps3 = ps3_ff;
      end else begin : g_sin_delay
         logic [30:0] ps1_ff, ps2_ff, ps3_ff;
         always_ff @(posedge clock) begin
            if (en) begin
               ps1_ff <= in_h.ps;
               ps2_ff <= ps1_ff;
               ps3_ff <= ps2_ff;
            end
         end
         assign ps3 = ps3_ff;
      end
   endgenerate

   assign out_valid = v3_ff;
   assign out_side = side3_ff;
   assign out_h.x2 = x2_3_ff;
   assign out_h.ps = ps3;
   assign out_h.pc = pc3_ff;

endmodule

// ===== rtl/e2mq_trig.sv =====
// Angle reduction, degree-to-radian scaling and the chain of Horner cells for one angle.
module e2mq_trig import e2mq_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [ANG_W-1:0] in_angle,
   input  logic [1:0]              in_tag,
   output logic                    out_valid,
   output logic [1:0]              out_tag,
   output angle_pair_type          out_sc
);

   localparam int SIDE_W = 2 + 2 + 1 + 30;

   logic [6:0] v_ff;
   logic [1:0] tag_ff [0:4];
   logic [1:0] tag6_ff;
   logic [R_W-1:0] r1_ff;
   logic [1:0] q2_ff, q3_ff, q4_ff, q5_ff;
   logic neg2_ff, neg3_ff, neg4_ff, neg5_ff;
   logic [UT_W-1:0] ut2_ff;
   logic [XM_W-1:0] xm3_ff;
   logic [29:0] x4_ff, x5_ff;
   logic [59:0] xx4_ff;
   logic [29:0] x2_5_ff;
   logic [29:0] sinm6_ff;
   logic [30:0] pc6_ff;
   logic [1:0] q6_ff;
   logic neg6_ff;
   angle_pair_type sc7_ff;

   logic [2:0] qq;
   int tt;
   logic [XM_W-1:0] xr;
   logic [29:0] x;
   logic [60:0] xxr;
   logic [60:0] sprod;
   logic signed [SC_W-1:0] sv, cv;

   horner_type h [0:NSTEPS];
   logic hv [0:NSTEPS];
   logic [SIDE_W-1:0] hs [0:NSTEPS];
   logic [1:0] e_tag, e_q;
   logic e_neg;
   logic [29:0] e_x;

   // Quadrant chosen so the remainder lies in (-45, +45] degrees.
   always_comb begin
      qq = 3'(r1_ff > R_W'(HALF_Q)) + 3'(r1_ff > R_W'(HALF_Q + QUARTER))
         + 3'(r1_ff > R_W'(HALF_Q + 2 * QUARTER)) + 3'(r1_ff > R_W'(HALF_Q + 3 * QUARTER));
      tt = int'(r1_ff) - int'(qq) * QUARTER;
   end

   assign xr = xm3_ff + XM_W'(1 << (ANG_SHIFT - 1));
   assign x = 30'(xr >> ANG_SHIFT);
   assign xxr = 61'(xx4_ff) + 61'(1 << 29);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         for (int i = 1; i < 5; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
         r1_ff <= (in_angle < 0) ? R_W'(int'(in_angle) + FULL) : R_W'(in_angle);
         q2_ff <= qq[1:0];
         neg2_ff <= tt < 0;
         ut2_ff <= (tt < 0) ? UT_W'(-tt) : UT_W'(tt);
         q3_ff <= q2_ff;
         neg3_ff <= neg2_ff;
         xm3_ff <= XM_W'(ut2_ff) * XM_W'(DEG_TO_RAD);
         q4_ff <= q3_ff;
         neg4_ff <= neg3_ff;
         x4_ff <= x;
         xx4_ff <= 60'(x) * 60'(x);
         q5_ff <= q4_ff;
         neg5_ff <= neg4_ff;
         x5_ff <= x4_ff;
         x2_5_ff <= xxr[59:30];
      end
   end

   assign hv[0] = v_ff[4];
   assign h[0].x2 = x2_5_ff;
   assign h[0].ps = 31'(Q30_ONE);
   assign h[0].pc = 31'(Q30_ONE);
   assign hs[0] = {tag_ff[4], q5_ff, neg5_ff, x5_ff};

   generate
      for (genvar g = 0; g < NSTEPS; g++) begin : g_cell
         e2mq_cell #(.STEP(g), .SIDE_W(SIDE_W)) u_cell (
            .clock(clock),
            .reset(reset),
            .en(en),
            .in_valid(hv[g]),
            .in_h(h[g]),
            .in_side(hs[g]),
            .out_valid(hv[g+1]),
            .out_h(h[g+1]),
            .out_side(hs[g+1])
         );
      end
   endgenerate

   assign {e_tag, e_q, e_neg, e_x} = hs[NSTEPS];
   assign sprod = 61'(e_x) * 61'(h[NSTEPS].ps) + 61'(1 << 29);

   always_ff @(posedge clock) begin
      if (en) begin
         sinm6_ff <= sprod[59:30];
         pc6_ff <= h[NSTEPS].pc;
         q6_ff <= e_q;
         neg6_ff <= e_neg;
         tag6_ff <= e_tag;
         sc7_ff.s <= (q6_ff == 2'd0) ? sv : (q6_ff == 2'd1) ? cv :
                     (q6_ff == 2'd2) ? -sv : -cv;
         sc7_ff.c <= (q6_ff == 2'd0) ? cv : (q6_ff == 2'd1) ? -sv :
                     (q6_ff == 2'd2) ? -cv : sv;
      end
   end

   assign sv = neg6_ff ? -$signed({2'b00, sinm6_ff}) : $signed({2'b00, sinm6_ff});
   assign cv = $signed({1'b0, pc6_ff});

   // The cell chain valid sits in hv; the two output stages follow it.
   logic v6_ff, v7_ff;
   logic [1:0] tag7_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= hv[NSTEPS];
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag7_ff <= tag6_ff;
      end
   end

   assign out_valid = v7_ff;
   assign out_tag = tag7_ff;
   assign out_sc = sc7_ff;

endmodule

// ===== rtl/e2mq_compose.sv =====
// Products and sums that form the matrix rows and the quaternion from the sines and cosines.
module e2mq_compose import e2mq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  angle_pair_type [2:0] in_full,
   input  angle_pair_type [2:0] in_half,
   output logic                 out_valid,
   output rsp_type [3:0]        out_rows
);

   localparam int SH = 30 - OUT_FRAC_BITS;
   localparam longint RND = (SH > 0) ? (64'd1 << SH) >> 1 : 0;

   typedef logic signed [SC_W-1:0] q30_type;

   logic [3:0] v_ff;
   q30_type shsp_ff, chsp_ff, chcb_ff, chsb_ff, shcp_ff, sbcp_ff, cbcp_ff;
   q30_type shcb_ff, sbsh_ff, chcp_ff, hcpc_ff, hsps_ff, hcps_ff, hspc_ff;
   q30_type sb1_ff, cb1_ff, sp1_ff, bs1_ff, bc1_ff;
   q30_type a0_ff, b0_ff, a2_ff, b2_ff;
   q30_type p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff, p7_ff, p8_ff;
   q30_type chcb2_ff, chsb2_ff, shcp2_ff, sbcp2_ff, cbcp2_ff, sp2_ff;
   q30_type shcb2_ff, sbsh2_ff, chcp2_ff;
   logic signed [SUM_W-1:0] sum_ff [0:12];
   rsp_type [3:0] rows_ff;

   q30_type sh, ch, sp, cp, sb, cb, hs, hc, ps, pc, bs, bc;

   // Signed Q30 product, magnitude rounded half up, so ties go away from zero.
   function automatic q30_type smulq(input q30_type a, input q30_type b);
      logic [SC_W-1:0] ua, ub;
      logic [63:0] m;
      begin
         ua = (a < 0) ? SC_W'(-a) : SC_W'(a);
         ub = (b < 0) ? SC_W'(-b) : SC_W'(b);
         m = ((64'(ua) * 64'(ub)) + 64'(1 << 29)) >> 30;
         smulq = ((a < 0) != (b < 0)) ? -$signed(SC_W'(m)) : $signed(SC_W'(m));
      end
   endfunction

   function automatic logic signed [VAL_W-1:0] to_field(input logic signed [SUM_W-1:0] v);
      logic [63:0] m;
      longint r;
      begin
         m = (v < 0) ? 64'(-v) : 64'(v);
         m = (m + 64'(RND)) >> SH;
         if (m > (64'd1 << 20)) begin
            m = 64'd1 << 20;
         end
         r = (v < 0) ? -longint'(m) : longint'(m);
         if (r > VAL_MAX) begin
            r = VAL_MAX;
         end
         if (r < VAL_MIN) begin
            r = VAL_MIN;
         end
         to_field = VAL_W'(r);
      end
   endfunction

   function automatic logic signed [SUM_W-1:0] ext(input q30_type a);
      ext = SUM_W'(a);
   endfunction

   assign sh = in_full[0].s;
   assign ch = in_full[0].c;
   assign sp = in_full[1].s;
   assign cp = in_full[1].c;
   assign sb = in_full[2].s;
   assign cb = in_full[2].c;
   assign hs = in_half[0].s;
   assign hc = in_half[0].c;
   assign ps = in_half[1].s;
   assign pc = in_half[1].c;
   assign bs = in_half[2].s;
   assign bc = in_half[2].c;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // First level of products.
         shsp_ff <= smulq(sh, sp);
         chsp_ff <= smulq(ch, sp);
         chcb_ff <= smulq(ch, cb);
         chsb_ff <= smulq(ch, sb);
         shcp_ff <= smulq(sh, cp);
         sbcp_ff <= smulq(sb, cp);
         cbcp_ff <= smulq(cb, cp);
         shcb_ff <= smulq(sh, cb);
         sbsh_ff <= smulq(sb, sh);
         chcp_ff <= smulq(ch, cp);
         hcpc_ff <= smulq(hc, pc);
         hsps_ff <= smulq(hs, ps);
         hcps_ff <= smulq(hc, ps);
         hspc_ff <= smulq(hs, pc);
         sb1_ff <= sb;
         cb1_ff <= cb;
         sp1_ff <= sp;
         bs1_ff <= bs;
         bc1_ff <= bc;

         // Second level, the bank terms.
         a0_ff <= smulq(shsp_ff, sb1_ff);
         b0_ff <= smulq(shsp_ff, cb1_ff);
         a2_ff <= smulq(chsp_ff, sb1_ff);
         b2_ff <= smulq(chsp_ff, cb1_ff);
         p1_ff <= smulq(hcpc_ff, bc1_ff);
         p2_ff <= smulq(hsps_ff, bs1_ff);
         p3_ff <= smulq(hcps_ff, bc1_ff);
         p4_ff <= smulq(hspc_ff, bs1_ff);
         p5_ff <= smulq(hspc_ff, bc1_ff);
         p6_ff <= smulq(hcps_ff, bs1_ff);
         p7_ff <= smulq(hcpc_ff, bs1_ff);
         p8_ff <= smulq(hsps_ff, bc1_ff);
         chcb2_ff <= chcb_ff;
         chsb2_ff <= chsb_ff;
         shcp2_ff <= shcp_ff;
         sbcp2_ff <= sbcp_ff;
         cbcp2_ff <= cbcp_ff;
         sp2_ff <= sp1_ff;
         shcb2_ff <= shcb_ff;
         sbsh2_ff <= sbsh_ff;
         chcp2_ff <= chcp_ff;

         sum_ff[0] <= ext(chcb2_ff) + ext(a0_ff);
         sum_ff[1] <= ext(b0_ff) - ext(chsb2_ff);
         sum_ff[2] <= ext(shcp2_ff);
         sum_ff[3] <= ext(sbcp2_ff);
         sum_ff[4] <= ext(cbcp2_ff);
         sum_ff[5] <= -ext(sp2_ff);
         sum_ff[6] <= ext(a2_ff) - ext(shcb2_ff);
         sum_ff[7] <= ext(sbsh2_ff) + ext(b2_ff);
         sum_ff[8] <= ext(chcp2_ff);
         sum_ff[9] <= ext(p1_ff) + ext(p2_ff);
         sum_ff[10] <= ext(p3_ff) + ext(p4_ff);
         sum_ff[11] <= ext(p5_ff) - ext(p6_ff);
         sum_ff[12] <= ext(p7_ff) - ext(p8_ff);

         for (int r = 0; r < 3; r++) begin
            rows_ff[r].row <= 2'(r);
            rows_ff[r].a <= to_field(sum_ff[3*r]);
            rows_ff[r].b <= to_field(sum_ff[3*r+1]);
            rows_ff[r].c <= to_field(sum_ff[3*r+2]);
            rows_ff[r].d <= '0;
            rows_ff[r].last <= 1'b0;
         end
         rows_ff[3].row <= ROW_QUAT;
         rows_ff[3].a <= to_field(sum_ff[9]);
         rows_ff[3].b <= to_field(sum_ff[10]);
         rows_ff[3].c <= to_field(sum_ff[11]);
         rows_ff[3].d <= to_field(sum_ff[12]);
         rows_ff[3].last <= 1'b1;
      end
   end

   assign out_valid = v_ff[3];
   assign out_rows = rows_ff;

endmodule

// ===== rtl/euler_to_matrix_and_quaternion.sv =====
// Top level: Euler angles in, rotation matrix rows and quaternion out.
//
// req channel: one word holds heading, pitch and bank, signed, 1/128 degree each.
// rsp channel: four words per request, in order matrix row 0, row 1, row 2 and
// the quaternion w, x, y, z. Values are signed Q2.16. tuser carries the row index
// (3 for the quaternion) and tlast marks the quaternion word.
// The first response word leaves once the request has passed the angle feed, both trig
// units, the collection registers, the compose stages and the response register. A new
// request is taken once the bank angle of the previous one has entered the trig units. The
// three angles of a request go one per cycle through two trig units (full and half angle) and
// the four response words leave through the single response register one per cycle, unless stalled.
// Each trig unit is a row of six Horner cells, three stages each, shared by the
// heading, pitch and bank of a request.
// Reset clears all valid flags; no result is pending afterward.
// When the receiver holds rsp_tready low with a word pending, the whole pipeline freezes, the
// pending word stays on rsp_tdata, and req_tready drops until it moves again.
module euler_to_matrix_and_quaternion import e2mq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // heading [15:0], pitch [31:16], bank [47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // value_a [17:0], value_b [35:18], value_c [53:36], value_d [71:54]
   output logic [1:0]  rsp_tuser,   // row_index [1:0]
   output logic        rsp_tlast    // last_of_run
);

   logic en;
   logic accept;
   logic busy_ff, busy_in;
   logic [1:0] phase_ff, phase_in;
   logic [47:0] item_ff;
   logic [15:0] sel;
   logic feed_valid;

   logic full_valid, half_valid;
   logic [1:0] full_tag, half_tag;
   angle_pair_type full_sc, half_sc;
   angle_pair_type [2:0] col_full_ff, col_half_ff;
   logic go_ff;

   logic comp_valid;
   rsp_type [3:0] comp_rows;
   rsp_type [3:0] bank_ff;
   logic ser_active_ff, ser_active_in;
   logic [1:0] ser_cnt_ff, ser_cnt_in;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en && (!busy_ff || phase_ff == 2'd3);
   assign accept = req_tvalid && req_tready;

   assign phase_in = accept ? 2'd0 : phase_ff + 2'd1;
   assign busy_in = accept || (busy_ff && phase_ff != 2'd3);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         phase_ff <= 2'd0;
      end else if (en) begin
         busy_ff <= busy_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_tdata;
      end
   end

   assign feed_valid = busy_ff && phase_ff != 2'd3;
   assign sel = (phase_ff == 2'd0) ? item_ff[15:0] :
                (phase_ff == 2'd1) ? item_ff[31:16] : item_ff[47:32];

   e2mq_trig u_trig_full (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(feed_valid),
      .in_angle($signed({sel, 1'b0})),
      .in_tag(phase_ff),
      .out_valid(full_valid),
      .out_tag(full_tag),
      .out_sc(full_sc)
   );

   e2mq_trig u_trig_half (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(feed_valid),
      .in_angle($signed({sel[15], sel})),
      .in_tag(phase_ff),
      .out_valid(half_valid),
      .out_tag(half_tag),
      .out_sc(half_sc)
   );

   // Sines and cosines of one request collect here; the bank angle arrives last.
   always_ff @(posedge clock) begin
      if (en && full_valid) begin
         col_full_ff[full_tag] <= full_sc;
      end
      if (en && half_valid) begin
         col_half_ff[half_tag] <= half_sc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff <= 1'b0;
      end else if (en) begin
         go_ff <= full_valid && full_tag == ANG_BANK;
      end
   end

   e2mq_compose u_compose (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(go_ff),
      .in_full(col_full_ff),
      .in_half(col_half_ff),
      .out_valid(comp_valid),
      .out_rows(comp_rows)
   );

   assign ser_active_in = comp_valid || (ser_active_ff && ser_cnt_ff != 2'd3);
   assign ser_cnt_in = comp_valid ? 2'd0 : ser_cnt_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_active_ff <= 1'b0;
         ser_cnt_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         ser_active_ff <= ser_active_in;
         ser_cnt_ff <= ser_cnt_in;
         rsp_valid_ff <= ser_active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (comp_valid) begin
            bank_ff <= comp_rows;
         end
         rsp_ff <= bank_ff[ser_cnt_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_ff.d, rsp_ff.c, rsp_ff.b, rsp_ff.a};
   assign rsp_tuser = rsp_ff.row;
   assign rsp_tlast = rsp_ff.last;

   // Both trig units see the same feed, so their outputs must stay in step.
   assert property (@(posedge clock) disable iff (reset)
      full_valid == half_valid && (!full_valid || full_tag == half_tag))
      else $error("trig units out of step");

   // A new set of results may only land when no run is active or the previous run is on its last word.
   assert property (@(posedge clock) disable iff (reset)
      en && comp_valid |-> !ser_active_ff || ser_cnt_ff == 2'd3)
      else $error("result bank overwritten mid-run");

   // The quaternion word, and only it, closes a run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (rsp_tuser == ROW_QUAT))
      else $error("tlast does not match the quaternion word");

   // Matrix rows carry no fourth element.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[71:54] == '0)
      else $error("matrix row with nonzero value_d");

endmodule
